[rtl/core/itp_pkg.sv]
// itp_pkg: shared types, character codes and helpers for the integer text parser.
// Used by every other file of the project; depends on nothing.
`timescale 1ns / 1ps

package itp_pkg;

  localparam int OUT_VALUE_W = 64;
  localparam int OUT_COUNT_W = 16;
  localparam int BASE_W      = 6;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_BASE = 1'b1;

  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

  localparam logic [CFG_DATA_W-1:0] NB_AUTO_OCT = 7'd0;
  localparam logic [CFG_DATA_W-1:0] NB_RESET    = 7'd10;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] DIGIT_NONE = 8'hFF;

  typedef enum logic [5:0] {
    PH_START      = 6'b000001,
    PH_AFTER_SIGN = 6'b000010,
    PH_ZERO_SEEN  = 6'b000100,
    PH_DIGITS     = 6'b001000,
    PH_STOPPED    = 6'b010000,
    PH_FAILED     = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   neg;
    logic   seen;
  } ctl_t;

  function automatic logic is_blank(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  // Digit weight of an alphanumeric character, DIGIT_NONE otherwise
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) d = c - CH_ZERO;
    else if ((c >= CH_LA) && (c <= CH_LZ)) d = c - CH_LA + 8'd10;
    else if ((c >= CH_UA) && (c <= CH_UZ)) d = c - CH_UA + 8'd10;
    else d = DIGIT_NONE;
    return d;
  endfunction

endpackage

[rtl/core/itp_step.sv]
// itp_step: next-state logic of the parser for one character (sign, prefix, digit).
// Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_step #(
  parameter int VALUE_BITS = 64,
  parameter int COUNT_BITS = 16
) (
  input  itp_pkg::ctl_t                  ctl_i,
  input  logic [VALUE_BITS-1:0]          acc_i,
  input  logic [itp_pkg::BASE_W-1:0]     base_i,
  input  logic [COUNT_BITS-1:0]          pos_i,
  input  logic [COUNT_BITS-1:0]          stop_i,
  input  logic [7:0]                     char_i,
  input  logic                           fin_i,
  input  logic                           smode_i,
  input  logic [itp_pkg::CFG_DATA_W-1:0] nbase_i,
  output itp_pkg::ctl_t                  ctl_o,
  output logic [VALUE_BITS-1:0]          acc_o,
  output logic [itp_pkg::BASE_W-1:0]     base_o,
  output logic [COUNT_BITS-1:0]          pos_o,
  output logic [COUNT_BITS-1:0]          stop_o
);

  logic [COUNT_BITS-1:0] pos_inc;
  logic [7:0]            dig;
  logic                  first;
  logic                  take;
  logic                  nb_auto;

  assign pos_inc = (pos_i == {COUNT_BITS{1'b1}}) ? pos_i : pos_i + 1'b1;
  assign dig     = itp_pkg::digit_value(char_i);
  assign nb_auto = nbase_i[itp_pkg::CFG_DATA_W-1] || (nbase_i == itp_pkg::NB_AUTO_OCT);
  assign pos_o   = pos_inc;

  always_comb begin
    ctl_o  = ctl_i;
    acc_o  = acc_i;
    base_o = base_i;
    stop_o = stop_i;
    first  = 1'b0;
    take   = 1'b0;

    unique case (ctl_i.phase)
      itp_pkg::PH_START: begin
        if (itp_pkg::is_blank(char_i)) begin
          ctl_o.phase = itp_pkg::PH_FAILED;
        end else if (smode_i && (char_i == itp_pkg::CH_PLUS || char_i == itp_pkg::CH_MINUS)) begin
          ctl_o.neg   = (char_i == itp_pkg::CH_MINUS);
          stop_o      = pos_inc;
          ctl_o.phase = itp_pkg::PH_AFTER_SIGN;
        end else begin
          first = 1'b1;
        end
      end
      itp_pkg::PH_AFTER_SIGN: begin
        if (itp_pkg::is_blank(char_i)) ctl_o.phase = itp_pkg::PH_FAILED;
        else first = 1'b1;
      end
      itp_pkg::PH_ZERO_SEEN: begin
        ctl_o.phase = itp_pkg::PH_DIGITS;
        if (char_i == itp_pkg::CH_LX || char_i == itp_pkg::CH_UX) begin
          base_o = itp_pkg::BASE_HEX;
          stop_o = pos_inc;
        end else begin
          // the held zero counts as a digit even if this character stops the scan
          ctl_o.seen = 1'b1;
          stop_o     = pos_i;
          take       = 1'b1;
        end
      end
      itp_pkg::PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
      end
    endcase

    // pick the base on the first character after the optional sign
    if (first) begin
      if (nb_auto && char_i == itp_pkg::CH_ZERO && !fin_i) begin
        base_o      = (nbase_i == itp_pkg::NB_AUTO_OCT) ? itp_pkg::BASE_OCT : itp_pkg::BASE_DEC;
        ctl_o.phase = itp_pkg::PH_ZERO_SEEN;
      end else begin
        base_o      = nb_auto ? itp_pkg::BASE_DEC : nbase_i[itp_pkg::BASE_W-1:0];
        ctl_o.phase = itp_pkg::PH_DIGITS;
        take        = 1'b1;
      end
    end

    if (take) begin
      if (dig < 8'(base_o)) begin
        acc_o      = acc_i * VALUE_BITS'(base_o) + VALUE_BITS'(dig);
        ctl_o.seen = 1'b1;
        stop_o     = pos_inc;
      end else begin
        ctl_o.phase = itp_pkg::PH_STOPPED;
      end
    end
  end

endmodule

[rtl/core/integer_text_parser.sv]
// integer_text_parser: top level of the streaming integer text parser.
// Depends on itp_pkg and itp_step.
`timescale 1ns / 1ps

// Takes one character beat per cycle while in_stall is low and gives one result beat
// per string through the finish and output registers. An optional sign (signed mode),
// a base fixed by number_base or detected from a 0x/0X prefix or a leading zero, then
// digits accumulate modulo 2^VALUE_BITS until the first non-digit; later characters
// are ignored. A result carries the value (two's complement when negative), the count
// of characters used and parse_ok; a failed parse gives zero value and count.
// Throughput is one character per cycle while in_stall is low, set by the parse stage:
// one multiply by a base of at most 63 and an add per character. The pipeline is input
// register, parse stage with a finish register, and a range check into the output
// register; each stage moves when the next is free, so a waiting result does not stop
// characters of the next string. Write configuration only while the block is idle.
module integer_text_parser #(
  parameter int VALUE_BITS = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_text_char,
  input  logic                                in_is_final,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [itp_pkg::OUT_VALUE_W-1:0]     out_parsed_value,
  output logic [itp_pkg::OUT_COUNT_W-1:0]     out_consumed_count,
  output logic                                out_parse_ok,
  input  logic                                cfg_wr_en,
  input  logic [itp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [itp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // configuration
  logic                           smode_r;
  logic [itp_pkg::CFG_DATA_W-1:0] nbase_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_fin_r;

  // parse state of the current string
  itp_pkg::ctl_t               ctl_r,  ctl_nxt;
  logic [VALUE_BITS-1:0]       acc_r,  acc_nxt;
  logic [itp_pkg::BASE_W-1:0]  base_r, base_nxt;
  logic [COUNT_BITS-1:0]       pos_r,  pos_nxt;
  logic [COUNT_BITS-1:0]       stop_r, stop_nxt;

  // finish register: state after the last character
  logic                  fin_valid_r;
  logic                  fin_ok_r;
  logic                  fin_neg_r;
  logic                  fin_smode_r;
  logic [VALUE_BITS-1:0] fin_acc_r;
  logic [COUNT_BITS-1:0] fin_stop_r;

  // output register
  logic                             out_valid_r;
  logic [itp_pkg::OUT_VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [itp_pkg::OUT_COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                             out_ok_r,    out_ok_nxt;

  logic out_free;
  logic fin_free;
  logic s1_go;
  logic s1_free;

  logic                  res_ok;
  logic [VALUE_BITS-1:0] res_val;
  logic [31:0]           stop_ext;

  // Stage advance: each stage loads when it is empty or its beat moves on
  assign out_free = !out_valid_r || !out_stall;
  assign fin_free = !fin_valid_r || out_free;
  assign s1_go    = s1_valid_r && (!s1_fin_r || fin_free);
  assign s1_free  = !s1_valid_r || s1_go;
  assign in_stall = !s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smode_r <= 1'b1;
      nbase_r <= itp_pkg::NB_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        itp_pkg::CFG_SIGNED_MODE: smode_r <= cfg_wdata[0];
        itp_pkg::CFG_NUMBER_BASE: nbase_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_free) begin
      s1_char_r <= in_text_char;
      s1_fin_r  <= in_is_final;
    end
  end

  itp_step #(
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .ctl_i  (ctl_r),
    .acc_i  (acc_r),
    .base_i (base_r),
    .pos_i  (pos_r),
    .stop_i (stop_r),
    .char_i (s1_char_r),
    .fin_i  (s1_fin_r),
    .smode_i(smode_r),
    .nbase_i(nbase_r),
    .ctl_o  (ctl_nxt),
    .acc_o  (acc_nxt),
    .base_o (base_nxt),
    .pos_o  (pos_nxt),
    .stop_o (stop_nxt)
  );

  // Parse state: advance on each character, return to string start after the last one
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_go && s1_fin_r)) begin
      ctl_r  <= '{phase: itp_pkg::PH_START, neg: 1'b0, seen: 1'b0};
      acc_r  <= '0;
      base_r <= itp_pkg::BASE_DEC;
      pos_r  <= '0;
      stop_r <= '0;
    end else if (s1_go) begin
      ctl_r  <= ctl_nxt;
      acc_r  <= acc_nxt;
      base_r <= base_nxt;
      pos_r  <= pos_nxt;
      stop_r <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_free) begin
      fin_valid_r <= s1_go && s1_fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_free && s1_go && s1_fin_r) begin
      fin_ok_r    <= ctl_nxt.seen && (ctl_nxt.phase != itp_pkg::PH_FAILED);
      fin_neg_r   <= ctl_nxt.neg;
      fin_smode_r <= smode_r;
      fin_acc_r   <= acc_nxt;
      fin_stop_r  <= stop_nxt;
    end
  end

  // Range check and negation. Negative values may reach 2^(VALUE_BITS-1),
  // positive signed values must stay below it.
  always_comb begin
    res_ok  = fin_ok_r;
    res_val = fin_acc_r;
    if (fin_ok_r && (fin_smode_r || fin_neg_r)) begin
      if (fin_neg_r) begin
        if (fin_acc_r[VALUE_BITS-1] && (|fin_acc_r[VALUE_BITS-2:0])) res_ok = 1'b0;
        else res_val = '0 - fin_acc_r;
      end else if (fin_acc_r[VALUE_BITS-1]) begin
        res_ok = 1'b0;
      end
    end
    stop_ext = 32'(fin_stop_r);
    if (res_ok) begin
      out_value_nxt = itp_pkg::OUT_VALUE_W'(res_val);
      out_count_nxt = (stop_ext > 32'h0000_FFFF) ? {itp_pkg::OUT_COUNT_W{1'b1}}
                                                 : stop_ext[itp_pkg::OUT_COUNT_W-1:0];
      out_ok_nxt    = 1'b1;
    end else begin
      out_value_nxt = '0;
      out_count_nxt = '0;
      out_ok_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_valid_r;
    end
  end

  // Hold the result beat while stalled
  always_ff @(posedge clk) begin
    if (out_free && fin_valid_r) begin
      out_value_r <= out_value_nxt;
      out_count_r <= out_count_nxt;
      out_ok_r    <= out_ok_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_parsed_value   = out_value_r;
  assign out_consumed_count = out_count_r;
  assign out_parse_ok       = out_ok_r;

endmodule

[rtl/core/itp_checker.sv]
// itp_checker: port-level assertions for integer_text_parser, attached by bind.
// Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [itp_pkg::OUT_VALUE_W-1:0] out_parsed_value,
  input logic [itp_pkg::OUT_COUNT_W-1:0] out_consumed_count,
  input logic                            out_parse_ok
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_parsed_value)
      && $stable(out_consumed_count) && $stable(out_parse_ok))
    else $error("result beat changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_parse_ok |-> out_parsed_value == '0 && out_consumed_count == '0)
    else $error("failed parse with nonzero value or count");

  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parse_ok |-> out_consumed_count != '0)
    else $error("successful parse consumed no characters");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind integer_text_parser itp_checker u_itp_checker (.*);

[tb/itp_checker.sv]
// itp_scoreboard: scoreboard for integer_text_parser; tracks register writes, predicts the
// result of each string from the character beats and compares the result beats.
// Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_scoreboard
  import itp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [7:0]             in_text_char,
  input  logic                   in_is_final,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [OUT_VALUE_W-1:0] out_parsed_value,
  input  logic [OUT_COUNT_W-1:0] out_consumed_count,
  input  logic                   out_parse_ok,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatches,
  output int                     pending
);

  localparam logic [OUT_VALUE_W-1:0] POS_LIMIT = {1'b0, {(OUT_VALUE_W-1){1'b1}}};
  localparam logic [OUT_VALUE_W-1:0] NEG_LIMIT = {1'b1, {(OUT_VALUE_W-1){1'b0}}};
  localparam logic [OUT_COUNT_W-1:0] POS_MAX   = '1;

  typedef struct {
    logic [OUT_VALUE_W-1:0] value;
    logic [OUT_COUNT_W-1:0] count;
    logic                   ok;
  } parse_result_t;

  parse_result_t expected_results[$];

  // register copies
  logic                   signed_en;
  logic [CFG_DATA_W-1:0]  base_sel;

  // per-string parse state
  phase_t                 phase;
  logic [OUT_VALUE_W-1:0] acc;
  logic                   neg;
  logic [BASE_W-1:0]      radix;
  logic [OUT_COUNT_W-1:0] char_pos;
  logic [OUT_COUNT_W-1:0] stop_pos;
  logic                   seen;

  int errs = 0;

  function automatic logic blank_byte(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  function automatic logic [7:0] char_weight(input logic [7:0] c);
    if ((c >= CH_ZERO) && (c <= CH_NINE)) return c - CH_ZERO;
    if ((c >= CH_LA) && (c <= CH_LZ)) return c - CH_LA + 8'd10;
    if ((c >= CH_UA) && (c <= CH_UZ)) return c - CH_UA + 8'd10;
    return DIGIT_NONE;
  endfunction

  function automatic logic [OUT_COUNT_W-1:0] sat_inc(input logic [OUT_COUNT_W-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  task automatic clear_string();
    phase    = PH_START;
    acc      = '0;
    neg      = 1'b0;
    radix    = BASE_DEC;
    char_pos = '0;
    stop_pos = '0;
    seen     = 1'b0;
  endtask

  task automatic take_digit(input logic [7:0] c, input logic [OUT_COUNT_W-1:0] p);
    logic [7:0] d;
    d = char_weight(c);
    if (d < {2'b00, radix}) begin
      acc      = acc * {{(OUT_VALUE_W-BASE_W){1'b0}}, radix} + {{(OUT_VALUE_W-8){1'b0}}, d};
      seen     = 1'b1;
      stop_pos = sat_inc(p);
    end else begin
      phase = PH_STOPPED;
    end
  endtask

  task automatic first_digit(input logic [7:0] c, input logic fin,
                             input logic [OUT_COUNT_W-1:0] p);
    logic signed [CFG_DATA_W-1:0] nb_s;
    nb_s = base_sel;
    if (nb_s <= 0) begin
      // a leading zero waits for the next char to tell a hex prefix from a digit
      if ((c == CH_ZERO) && !fin) begin
        radix = (nb_s == 0) ? BASE_OCT : BASE_DEC;
        phase = PH_ZERO_SEEN;
        return;
      end
      radix = BASE_DEC;
    end else begin
      radix = base_sel[BASE_W-1:0];
    end
    phase = PH_DIGITS;
    take_digit(c, p);
  endtask

  task automatic predict_char(input logic [7:0] c, input logic fin);
    logic [OUT_COUNT_W-1:0] p;
    logic                   good;
    logic [OUT_VALUE_W-1:0] v;
    parse_result_t          r;
    p = char_pos;
    case (phase)
      PH_START: begin
        if (blank_byte(c)) begin
          phase = PH_FAILED;
        end else if (signed_en && ((c == CH_PLUS) || (c == CH_MINUS))) begin
          neg      = (c == CH_MINUS);
          stop_pos = sat_inc(p);
          phase    = PH_AFTER_SIGN;
        end else begin
          first_digit(c, fin, p);
        end
      end
      PH_AFTER_SIGN: begin
        if (blank_byte(c)) phase = PH_FAILED;
        else first_digit(c, fin, p);
      end
      PH_ZERO_SEEN: begin
        phase = PH_DIGITS;
        if ((c == CH_LX) || (c == CH_UX)) begin
          radix    = BASE_HEX;
          stop_pos = sat_inc(p);
        end else begin
          seen     = 1'b1;
          stop_pos = p;
          take_digit(c, p);
        end
      end
      PH_DIGITS: take_digit(c, p);
      default: ;
    endcase
    char_pos = sat_inc(p);

    if (fin) begin
      good = seen && (phase != PH_FAILED);
      v    = acc;
      if (good && (signed_en || neg)) begin
        if (neg) begin
          if (v > NEG_LIMIT) good = 1'b0;
          else v = -v;
        end else if (v > POS_LIMIT) begin
          good = 1'b0;
        end
      end
      r.value = good ? v : '0;
      r.count = good ? stop_pos : '0;
      r.ok    = good;
      expected_results.push_back(r);
      clear_string();
    end
  endtask

  always @(posedge clk) begin
    parse_result_t want;
    if (!rst_n) begin
      signed_en = 1'b1;
      base_sel  = NB_RESET;
      clear_string();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result beat: value %h count %0d ok %b",
                     $time, out_parsed_value, out_consumed_count, out_parse_ok);
        end else begin
          want = expected_results.pop_front();
          if ((want.value !== out_parsed_value) || (want.count !== out_consumed_count) ||
              (want.ok !== out_parse_ok)) begin
            errs++;
            if (errs <= 10)
              $display({"%0t: mismatch: exp value %h count %0d ok %b,",
                        " got value %h count %0d ok %b"},
                       $time, want.value, want.count, want.ok,
                       out_parsed_value, out_consumed_count, out_parse_ok);
          end
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == CFG_SIGNED_MODE) signed_en = cfg_wdata[0];
        else if (cfg_index == CFG_NUMBER_BASE) base_sel = cfg_wdata;
      end
      if (in_valid && !in_stall) predict_char(in_text_char, in_is_final);
    end
    mismatches <= errs;
    pending    <= expected_results.size();
  end

endmodule

[tb/tb_integer_text_parser.sv]
// tb_integer_text_parser: stimulus and verdict for integer_text_parser (instantiated here);
// the checking is done by itp_scoreboard beside it. Depends on itp_pkg and itp_scoreboard.
`timescale 1ns / 1ps

module tb_integer_text_parser;
  import itp_pkg::*;

  // Run bounds. A correct run is roughly 2.1k character beats; each may wait out a
  // burst gap and several stalled result beats, and every phase change drains the
  // block. The limit leaves a wide margin over such a run.
  localparam int RUN_LIMIT    = 400_000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_ITEMS  = 120;
  localparam int SETTLE       = 10;

  // auto base, leading zero decimal: -1 in the 7-bit signed register
  localparam logic [CFG_DATA_W-1:0] NB_AUTO_DEC = 7'h7F;
  localparam logic [CFG_DATA_W-1:0] NB_MOST_NEG = 7'h40;

  typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_RARE} stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_text_char = '0;
  logic                   in_is_final = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [OUT_VALUE_W-1:0] out_parsed_value;
  logic [OUT_COUNT_W-1:0] out_consumed_count;
  logic                   out_parse_ok;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int mismatches;
  int pending;
  int cycle_count = 0;

  // Stimulus state: what the block is currently set to, the string being sent,
  // and the sender's burst bookkeeping.
  logic                  cur_sm = 1'b1;
  logic [CFG_DATA_W-1:0] cur_nb = NB_RESET;
  logic [7:0]            text_buf[$];
  int                    useful_len;
  int                    burst_left = 0;
  bit                    gaps_on = 1'b1;
  int                    items_done = 0;

  // Values right at and past the 64-bit limits, signed and unsigned
  string limit_texts[9] = '{
    "9223372036854775807", "9223372036854775808", "9223372036854775809",
    "18446744073709551615", "18446744073709551616",
    "0x7fffffffffffffff", "0x8000000000000000", "0XFFFFFFFFFFFFFFFF",
    "0x10000000000000000"
  };

  integer_text_parser u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_char       (in_text_char),
    .in_is_final        (in_is_final),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_parsed_value   (out_parsed_value),
    .out_consumed_count (out_consumed_count),
    .out_parse_ok       (out_parse_ok),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  itp_scoreboard u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_char       (in_text_char),
    .in_is_final        (in_is_final),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_parsed_value   (out_parsed_value),
    .out_consumed_count (out_consumed_count),
    .out_parse_ok       (out_parse_ok),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver backpressure: switch between patterns at random intervals, so stalls
  // land on every phase of the result pipeline, with stall-free stretches in between.
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_tick = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
      STALL_PERIODIC: out_stall <= (stall_tick % 5) < 3;
      default:        out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [7:0] digit_char(input int unsigned v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  // Present one character beat and hold it until taken. Valid stays high across
  // back-to-back beats; it only drops for a gap between bursts.
  task automatic send_beat(input logic [7:0] c, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid     <= 1'b1;
    in_text_char <= c;
    in_is_final  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Send text_buf as one string, last char marked final.
  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_beat(text_buf[i], i == text_buf.size() - 1);
    items_done += text_buf.size();
  endtask

  task automatic send_literal(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    useful_len = s.len();
    send_text();
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic sm, input logic [CFG_DATA_W-1:0] nb);
    drain();
    write_reg(CFG_SIGNED_MODE, {{(CFG_DATA_W-1){1'b0}}, sm});
    write_reg(CFG_NUMBER_BASE, nb);
    cur_sm = sm;
    cur_nb = nb;
  endtask

  // Build one random string into text_buf. Most are well-formed numbers for the
  // current base with random content; the rest are limit values, raw noise and
  // strings broken by a blank or a stray byte. Trailing junk is not counted.
  task automatic build_random_text();
    int                           kind, ndig, radix, span, junk, k;
    string                        lt;
    logic signed [CFG_DATA_W-1:0] nb_s;
    nb_s = cur_nb;
    text_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      ndig = $urandom_range(1, 8);
      repeat (ndig) text_buf.push_back(8'($urandom_range(0, 255)));
      useful_len = ndig;
    end else if (kind < 22) begin
      if ($urandom_range(0, 1)) text_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      lt = limit_texts[$urandom_range(0, 8)];
      for (int i = 0; i < lt.len(); i++) text_buf.push_back(lt[i]);
      useful_len = text_buf.size();
    end else begin
      // a sign is offered half the time when it is accepted, sometimes when it is not
      if ($urandom_range(0, cur_sm ? 1 : 5) == 0)
        text_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      if ($urandom_range(0, 11) == 0) text_buf.push_back(blank_char());
      radix = nb_s;
      if (nb_s <= 0) begin
        case ($urandom_range(0, 2))
          0: begin
            text_buf.push_back(CH_ZERO);
            text_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            radix = 16;
          end
          1: begin
            text_buf.push_back(CH_ZERO);
            radix = (nb_s == 0) ? 8 : 10;
          end
          default: radix = 10;
        endcase
      end
      span = (radix > 36) ? 36 : radix;
      // long runs overflow and wrap even in base 2
      ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 70) : $urandom_range(1, 20);
      repeat (ndig) text_buf.push_back(digit_char($urandom_range(0, span - 1)));
      if ((text_buf.size() > 0) && ($urandom_range(0, 19) == 0)) begin
        k = $urandom_range(0, text_buf.size() - 1);
        text_buf[k] = 8'($urandom_range(0, 255));
      end
      useful_len = text_buf.size();
      junk = $urandom_range(0, 3);
      repeat (junk) text_buf.push_back(8'($urandom_range(0, 255)));
      if (text_buf.size() == 0) begin
        text_buf.push_back(8'($urandom_range(0, 255)));
        useful_len = 1;
      end
    end
  endtask

  initial begin
    logic                  plan_sm[10];
    logic [CFG_DATA_W-1:0] plan_nb[10];
    int                    phase_no, phase_items, r;
    logic                  sm;
    logic [CFG_DATA_W-1:0] nb;

    plan_sm = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    plan_nb = '{NB_RESET, NB_AUTO_DEC, NB_AUTO_OCT, 7'd1, 7'd36, 7'd16, 7'd2,
                NB_MOST_NEG, 7'd63, NB_AUTO_DEC};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: reset settings first (signed, base ten)
    send_literal("7");
    send_literal(" 1");      // blank first fails
    send_literal("-\t3");    // blank after sign fails
    send_literal("+");       // sign with no digit
    send_literal("z");       // no digit of the base
    send_literal("-08");
    // auto base, leading zero octal: hex prefix, bare prefix, octal, lone zero
    configure(1'b1, NB_AUTO_OCT);
    send_literal("0x1F");
    send_literal("0X");
    send_literal("017");
    send_literal("0");
    // unsigned, base 36: letters of both cases, sign not accepted
    configure(1'b0, 7'd36);
    send_literal("Zz");
    send_literal("-5");

    // Random phases: planned extremes first, then random settings. Each phase
    // change drains the block, which also pauses the sender until all results came.
    phase_no = 0;
    while (items_done < RANDOM_ITEMS) begin
      if (phase_no < 10) begin
        sm = plan_sm[phase_no];
        nb = plan_nb[phase_no];
      end else begin
        sm = 1'($urandom_range(0, 1));
        r  = $urandom_range(0, 37);
        nb = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) : 7'(r - 1);
      end
      configure(sm, nb);
      gaps_on = ($urandom_range(0, 3) != 0);
      phase_items = 0;
      while ((phase_items < PHASE_ITEMS) && (items_done < RANDOM_ITEMS)) begin
        build_random_text();
        send_text();
        phase_items += useful_len;
      end
      phase_no++;
    end

    drain();
    @(posedge clk);
    if ((mismatches == 0) && (pending == 0)) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[integer_text_parser.f]
rtl/core/itp_pkg.sv
rtl/core/itp_step.sv
rtl/core/integer_text_parser.sv
rtl/core/itp_checker.sv
tb/itp_checker.sv
tb/tb_integer_text_parser.sv
